// ===== sv/kwctc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keyboard wedge card track capture - shared definitions
// Operation codes, register indexes, key codes and the accent folding table.
// ----------------------------------------------------------------------------
package kwctc_pkg;

    // Request operations
    typedef enum logic [1:0] {
        OP_KEY   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_RD1   = 2'd2,
        OP_RD2   = 2'd3
    } t_op;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_ENABLE      = 3'd0,
        CFG_IDLE_MINUS  = 3'd1,
        CFG_ALT_LAYOUT  = 3'd2,
        CFG_SINGLE      = 3'd3,
        CFG_TIMEOUT     = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        TRK_NONE = 2'd0,
        TRK_1    = 2'd1,
        TRK_2    = 2'd2
    } t_track;

    typedef enum logic {
        CAP_IDLE   = 1'b0,
        CAP_ACTIVE = 1'b1
    } t_cap_state;

    localparam int KEY_W = 17;

    localparam logic signed [KEY_W-1:0] KEY_IDLE_HIGH  = 17'sd61440;
    localparam logic signed [KEY_W-1:0] KEY_IDLE_MINUS = -17'sd999;
    localparam logic signed [KEY_W-1:0] KEY_PERCENT    = 17'sd37;
    localparam logic signed [KEY_W-1:0] KEY_SEMICOLON  = 17'sd59;
    localparam logic signed [KEY_W-1:0] KEY_QUESTION   = 17'sd63;
    localparam logic signed [KEY_W-1:0] KEY_UNDERSCORE = 17'sd95;
    localparam logic signed [KEY_W-1:0] KEY_ESC        = 17'sd27;
    localparam logic signed [KEY_W-1:0] KEY_CR         = 17'sd13;
    localparam logic signed [KEY_W-1:0] KEY_ALT_START  = 17'sd241;

    localparam logic [7:0] TIMEOUT_RESET = 8'd8;

    // Fold accented letters to plain ASCII; return the low byte otherwise.
    function automatic logic [7:0] fold_accent(input logic signed [KEY_W-1:0] k);
        logic [7:0] f;
        begin
            f = k[7:0];
            case (k)
                -17'sd63, 17'sd193: f = 8'd65;
                -17'sd55:           f = 8'd69;
                -17'sd51:           f = 8'd73;
                -17'sd45, 17'sd224: f = 8'd79;
                -17'sd38, 17'sd218: f = 8'd85;
                -17'sd31:           f = 8'd97;
                -17'sd23:           f = 8'd101;
                -17'sd19:           f = 8'd105;
                -17'sd13, 17'sd243: f = 8'd111;
                -17'sd6,  17'sd250: f = 8'd117;
                default:            f = k[7:0];
            endcase
            return f;
        end
    endfunction

endpackage
`default_nettype wire

// ===== sv/keyboard_wedge_card_track_capture.sv =====
// A request is held in the input register once accepted; its result is loaded
// into the output register as soon as that register is free or being drained.
// Throughput: one request per cycle unless the output stalls; the key update
// is one pass of logic between the input and output registers, one store write.
// Reset (synchronous, active low) clears capture state, lengths and ready flags
// and returns config to its reset values; track stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keyboard wedge card track capture
// Pulls magnetic-stripe track data out of a keystroke stream, swallowing the
// consumed keys, and serves read-back of the captured track bytes.
// ----------------------------------------------------------------------------
module keyboard_wedge_card_track_capture
    import kwctc_pkg::*;
#(
    parameter int TRACK1_DEPTH = 80,
    parameter int TRACK2_DEPTH = 50
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,

    // Configuration write port
    input  wire logic                                  i_cfg_we,
    input  wire logic [2:0]                            i_cfg_index,
    input  wire logic [7:0]                            i_cfg_data,

    // Request channel
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic [1:0]                            i_op,
    input  wire logic signed [16:0]                    i_key_in,
    input  wire logic [15:0]                           i_time_now,
    input  wire logic [6:0]                            i_read_index,

    // Result channel
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic signed [16:0]                         o_key_out,
    output logic                                       o_card_ready,
    output logic                                       o_track1_done,
    output logic                                       o_capturing,
    output logic [7:0]                                 o_read_byte,
    output logic [$clog2(TRACK1_DEPTH+1)-1:0]          o_track1_length,
    output logic [$clog2(TRACK2_DEPTH+1)-1:0]          o_track2_length
);

    localparam int A1W = $clog2(TRACK1_DEPTH);
    localparam int A2W = $clog2(TRACK2_DEPTH);
    localparam int L1W = $clog2(TRACK1_DEPTH + 1);
    localparam int L2W = $clog2(TRACK2_DEPTH + 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic       r_enable;
    logic       r_idle_minus;
    logic       r_alt_layout;
    logic       r_single;
    logic [7:0] r_timeout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= 1'b0;
            r_idle_minus <= 1'b0;
            r_alt_layout <= 1'b0;
            r_single     <= 1'b0;
            r_timeout    <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ENABLE:     r_enable     <= i_cfg_data[0];
                CFG_IDLE_MINUS: r_idle_minus <= i_cfg_data[0];
                CFG_ALT_LAYOUT: r_alt_layout <= i_cfg_data[0];
                CFG_SINGLE:     r_single     <= i_cfg_data[0];
                CFG_TIMEOUT:    r_timeout    <= i_cfg_data;
                default: ;  // unmapped index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: input register feeds the output register. The output
    // register holds under stall; the input register moves forward as soon
    // as the output register is free or being drained.
    // ------------------------------------------------------------------
    logic r_in_valid;
    logic r_out_valid;
    logic move;
    logic in_accept;

    assign move       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !move;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;

    t_op                     r_in_op;
    logic signed [KEY_W-1:0] r_in_key;
    logic [15:0]             r_in_time;
    logic [6:0]              r_in_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (move) begin
                r_in_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_op   <= t_op'(i_op);
            r_in_key  <= i_key_in;
            r_in_time <= i_time_now;
            r_in_idx  <= i_read_index;
        end
    end

    // ------------------------------------------------------------------
    // Capture state
    // ------------------------------------------------------------------
    t_cap_state r_state,     n_state;
    t_track     r_track,     n_track;
    logic [1:0] r_ready,     n_ready;
    logic [15:0] r_last_tick, n_last_tick;
    logic [L1W-1:0] r_len1,  n_len1;
    logic [L2W-1:0] r_len2,  n_len2;

    logic signed [KEY_W-1:0] n_key;
    logic signed [KEY_W-1:0] r_out_key;
    logic signed [KEY_W-1:0] idle_key;
    logic signed [KEY_W-1:0] t1_start;
    logic signed [KEY_W-1:0] t2_start;
    logic [15:0]             elapsed;
    logic                    is_start;
    logic                    t1_end;
    logic                    t2_end;
    logic                    w1_en;
    logic                    w2_en;
    logic [7:0]              w1_data;
    logic                    rd_hit;

    assign idle_key = r_idle_minus ? KEY_IDLE_MINUS : KEY_IDLE_HIGH;
    assign t1_start = r_alt_layout ? KEY_SEMICOLON : KEY_PERCENT;
    assign t2_start = r_alt_layout ? KEY_PERCENT : KEY_SEMICOLON;
    assign elapsed  = r_in_time - r_last_tick;
    assign w1_data  = fold_accent(r_in_key);

    assign is_start = (r_in_key == KEY_PERCENT) || (r_in_key == KEY_SEMICOLON) ||
                      (r_in_key == KEY_ALT_START);
    assign t1_end   = (r_alt_layout && (r_in_key == KEY_CR)) ||
                      (r_in_key == KEY_QUESTION) || (r_in_key == KEY_UNDERSCORE);
    assign t2_end   = (r_in_key == KEY_CR) || (r_in_key == KEY_UNDERSCORE) ||
                      (r_in_key == KEY_QUESTION);

    // Next state and result key for the request in the input register
    always_comb begin
        n_state     = r_state;
        n_track     = r_track;
        n_ready     = r_ready;
        n_last_tick = r_last_tick;
        n_len1      = r_len1;
        n_len2      = r_len2;
        n_key       = idle_key;
        w1_en       = 1'b0;
        w2_en       = 1'b0;

        unique case (r_in_op)
            OP_KEY: begin
                n_key = r_in_key;
                // Capture off, or the minus no-key code: pass the key untouched
                if (r_enable && (r_in_key != KEY_IDLE_MINUS)) begin
                    if (r_state == CAP_ACTIVE) begin
                        if (r_in_key == idle_key) begin
                            // No key: check for an abandoned swipe
                            if (elapsed > {8'd0, r_timeout}) begin
                                if ((r_track == TRK_1) && (r_len1 == '0)) begin
                                    n_key = t1_start;
                                end else if ((r_track == TRK_2) && (r_len2 == '0)) begin
                                    n_key = t2_start;
                                end
                                n_state = CAP_IDLE;
                            end
                        end else begin
                            if (r_track == TRK_1) begin
                                if (t1_end) begin
                                    n_state = CAP_IDLE;
                                    if (r_single) begin
                                        n_ready[1] = 1'b1;
                                        n_len2     = '0;
                                    end else begin
                                        n_ready[0] = 1'b1;
                                    end
                                end else if (r_len1 < L1W'(TRACK1_DEPTH)) begin
                                    w1_en  = 1'b1;
                                    n_len1 = r_len1 + L1W'(1);
                                end else begin
                                    n_state = CAP_IDLE;  // store full
                                end
                            end else if (r_track == TRK_2) begin
                                if (t2_end) begin
                                    n_state    = CAP_IDLE;
                                    n_ready[1] = 1'b1;
                                    if (r_single) begin
                                        n_len1 = '0;
                                    end
                                end else if (r_len2 < L2W'(TRACK2_DEPTH)) begin
                                    w2_en  = 1'b1;
                                    n_len2 = r_len2 + L2W'(1);
                                end else begin
                                    n_state = CAP_IDLE;  // store full
                                end
                            end
                            n_last_tick = r_in_time;
                            n_key       = idle_key;
                        end
                    end else if (is_start) begin
                        n_state     = CAP_ACTIVE;
                        n_last_tick = r_in_time;
                        if (r_in_key == t1_start) begin
                            n_len1  = '0;
                            n_track = TRK_1;
                        end else begin
                            n_len2  = '0;
                            n_track = TRK_2;
                        end
                        n_key = idle_key;
                    end

                    // Card waiting: swallow everything but escape and no-key codes
                    if ((n_key != KEY_ESC) && (n_key != KEY_IDLE_HIGH) &&
                        (n_key != KEY_IDLE_MINUS) && (n_track != TRK_NONE) &&
                        (n_ready != 2'b00)) begin
                        n_key = idle_key;
                    end
                end
            end
            OP_CLEAR: n_ready = 2'b00;
            OP_RD1:   ;
            OP_RD2:   ;
        endcase
    end

    assign rd_hit = ((r_in_op == OP_RD1) && ({1'b0, r_in_idx} < 8'(r_len1))) ||
                    ((r_in_op == OP_RD2) && ({1'b0, r_in_idx} < 8'(r_len2)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= CAP_IDLE;
            r_track     <= TRK_NONE;
            r_ready     <= 2'b00;
            r_last_tick <= '0;
            r_len1      <= '0;
            r_len2      <= '0;
        end else if (move) begin
            r_state     <= n_state;
            r_track     <= n_track;
            r_ready     <= n_ready;
            r_last_tick <= n_last_tick;
            r_len1      <= n_len1;
            r_len2      <= n_len2;
        end
    end

    // ------------------------------------------------------------------
    // Track stores: one write and one registered read per request. Reads
    // happen as the request moves to the output register, so every earlier
    // write is already in place.
    // ------------------------------------------------------------------
    logic [7:0] r_mem1 [TRACK1_DEPTH];
    logic [7:0] r_mem2 [TRACK2_DEPTH];
    logic [7:0] r_rd1_q;
    logic [7:0] r_rd2_q;
    logic       r_rd_hit;
    logic       r_rd_sel;

    always_ff @(posedge i_clk) begin
        if (move) begin
            if (w1_en) begin
                r_mem1[r_len1[A1W-1:0]] <= w1_data;
            end
            r_rd1_q <= r_mem1[r_in_idx[A1W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            if (w2_en) begin
                r_mem2[r_len2[A2W-1:0]] <= r_in_key[7:0];
            end
            r_rd2_q <= r_mem2[r_in_idx[A2W-1:0]];
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_key <= n_key;
            r_rd_hit  <= rd_hit;
            r_rd_sel  <= (r_in_op == OP_RD2);
        end
    end

    // Status fields come straight from the state: it only changes when a new
    // result is loaded, so it always matches the result on display.
    always_comb begin
        o_capturing = (r_state == CAP_ACTIVE);
    end

    assign o_key_out       = r_out_key;
    assign o_card_ready    = r_ready[1];
    assign o_track1_done   = r_ready[0];
    assign o_track1_length = r_len1;
    assign o_track2_length = r_len2;
    assign o_read_byte     = r_rd_hit ? (r_rd_sel ? r_rd2_q : r_rd1_q) : 8'd0;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len1 <= L1W'(TRACK1_DEPTH)) && (r_len2 <= L2W'(TRACK2_DEPTH)))
        else $error("track length past store depth");

    a_track_when_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == CAP_ACTIVE) |-> (r_track != TRK_NONE))
        else $error("capturing with no track open");

    a_clear_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && (r_in_op == OP_CLEAR)) |=> (r_ready == 2'b00))
        else $error("ready flags survived a clear request");

    a_write_needs_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && (w1_en || w2_en)) |-> (r_state == CAP_ACTIVE))
        else $error("store written while not capturing");

endmodule
`default_nettype wire
